FILE: rtl/unix_time_to_calendar_date_macros.svh
// Assertion macros shared by the calendar date converter RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef UNIX_TIME_TO_CALENDAR_DATE_MACROS_SVH
`define UNIX_TIME_TO_CALENDAR_DATE_MACROS_SVH
`ifndef SYNTHESIS
`define UCD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define UCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define UCD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define UCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/ucd_pkg.sv
// Shared widths, constants and the month start table of the date converter.
// No dependencies.
package ucd_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int WEEKDAY_W = 3;
   localparam int DOY_W     = 9;

   localparam int NUM_STAGES = 6;

   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [10:0] DAYS_PER_BLOCK = 11'd1461;
   localparam logic [10:0] YEAR1_START    = 11'd365;
   localparam logic [10:0] YEAR2_START    = 11'd730;
   localparam logic [10:0] YEAR3_START    = 11'd1096;
   localparam logic [1:0]  LEAP_SLOT      = 2'd2;
   localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
   localparam logic [DOY_W-1:0]  LAST_LEAP_DOY = 9'd365;

   // Reciprocal multipliers, exact over the full operand width.
   localparam int DAY_SHIFT = 35;
   localparam logic [25:0] DAY_RECIP = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   localparam int BLK_SHIFT = 27;
   localparam logic [16:0] BLK_RECIP = 17'(((64'd1 << BLK_SHIFT) + 64'd1460) / 64'd1461);
   localparam int WK_SHIFT = 20;
   localparam logic [17:0] WK_RECIP = 18'(((64'd1 << WK_SHIFT) + 64'd6) / 64'd7);
   localparam int HR_SHIFT = 21;
   localparam logic [13:0] HR_RECIP = 14'(((64'd1 << HR_SHIFT) + 64'd224) / 64'd225);
   localparam int MIN_SHIFT = 14;
   localparam logic [10:0] MIN_RECIP = 11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

   function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                    input logic [MONTH_W-1:0] idx);
      logic [DOY_W-1:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

FILE: rtl/ucd_month_find.sv
// Splits a zero-based day of year into month and day of month.
// Depends on ucd_pkg for widths and the month start table.
module ucd_month_find (
   input  logic [ucd_pkg::DOY_W-1:0]   doy,
   input  logic                        leap,
   output logic [ucd_pkg::MONTH_W-1:0] month,
   output logic [ucd_pkg::DAY_W-1:0]   day
);
   import ucd_pkg::*;

   logic [DOY_W-1:0] start;
   logic [DOY_W-1:0] offset;

   always_comb begin
      month = 4'd1;
      start = '0;
      for (int unsigned i = 1; i < 12; i++) begin
         if (doy >= month_start(leap, MONTH_W'(i))) begin
            month = MONTH_W'(i + 1);
            start = month_start(leap, MONTH_W'(i));
         end
      end
      offset = doy - start;
      day    = offset[DAY_W-1:0] + 5'd1;
   end

endmodule

FILE: rtl/unix_time_to_calendar_date.sv
// Six-stage pipeline; reciprocal multipliers replace every division.
// One request is taken every cycle unless the pipe is full and its output is stalled.
// A stalled output holds its stage; earlier stages keep filling until the pipe is full.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
// Depends on ucd_pkg, ucd_month_find and unix_time_to_calendar_date_macros.svh.
`include "unix_time_to_calendar_date_macros.svh"
module unix_time_to_calendar_date (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // epoch_seconds[31:0]
   input  logic [ucd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // second[37:32], weekday[40:38], zero[47:41]
   output logic [ucd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ucd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[5] = !valid_ff[5] || rsp_tready;
      adv[4] = !valid_ff[4] || adv[5];
      adv[3] = !valid_ff[3] || adv[4];
      adv[2] = !valid_ff[2] || adv[3];
      adv[1] = !valid_ff[1] || adv[2];
      adv[0] = !valid_ff[0] || adv[1];
      valid_in = (adv & {valid_ff[NUM_STAGES-2:0], req_tvalid}) | (~adv & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // Stage 0: whole days.
   logic [50:0] day_prod;
   logic [15:0] days_s0_in, days_s0_ff;
   logic [16:0] tlo_s0_in, tlo_s0_ff;

   assign day_prod   = 51'(req_tdata[31:7]) * 51'(DAY_RECIP);
   assign days_s0_in = day_prod[DAY_SHIFT +: 16];
   assign tlo_s0_in  = req_tdata[16:0];

   // Stage 1: second of day, four-year block, weekday quotient.
   logic [32:0] day_secs;
   logic [32:0] blk_prod;
   logic [16:0] wk_x;
   logic [34:0] wk_prod;
   logic [16:0] sod_s1_in, sod_s1_ff;
   logic [5:0]  blk_s1_in, blk_s1_ff;
   logic [10:0] days_s1_in, days_s1_ff;
   logic [2:0]  wx_s1_in, wx_s1_ff;
   logic [2:0]  wq_s1_in, wq_s1_ff;

   assign day_secs   = 33'(days_s0_ff) * 33'(SECS_PER_DAY);
   assign sod_s1_in  = tlo_s0_ff - day_secs[16:0];
   assign blk_prod   = 33'(days_s0_ff) * 33'(BLK_RECIP);
   assign blk_s1_in  = blk_prod[BLK_SHIFT +: 6];
   assign days_s1_in = days_s0_ff[10:0];
   assign wk_x       = 17'(days_s0_ff) + 17'd3;
   assign wk_prod    = 35'(wk_x) * 35'(WK_RECIP);
   assign wx_s1_in   = wk_x[2:0];
   assign wq_s1_in   = wk_prod[WK_SHIFT +: 3];

   // Stage 2: hour, weekday, day within block.
   logic [26:0] hr_prod;
   logic [16:0] blk_days;
   logic [2:0]  wk_rem;
   logic [11:0] sod_s2_in, sod_s2_ff;
   logic [HOUR_W-1:0]    hour_s2_in, hour_s2_ff;
   logic [WEEKDAY_W-1:0] weekday_s2_in, weekday_s2_ff;
   logic [10:0] doff_s2_in, doff_s2_ff;
   logic [5:0]  blk_s2_in, blk_s2_ff;

   assign hr_prod       = 27'(sod_s1_ff[16:4]) * 27'(HR_RECIP);
   assign hour_s2_in    = hr_prod[HR_SHIFT +: HOUR_W];
   assign sod_s2_in     = sod_s1_ff[11:0];
   assign wk_rem        = wx_s1_ff - 3'(wq_s1_ff * 3'd7);
   assign weekday_s2_in = wk_rem + 3'd1;
   assign blk_days      = 17'(blk_s1_ff) * 17'(DAYS_PER_BLOCK);
   assign doff_s2_in    = days_s1_ff - blk_days[10:0];
   assign blk_s2_in     = blk_s1_ff;

   // Stage 3: seconds within hour, year and day of year.
   logic [16:0] hour_secs;
   logic [1:0]  yoff;
   logic [10:0] ystart;
   logic [10:0] doy_full;
   logic [11:0] rh_s3_in, rh_s3_ff;
   logic [HOUR_W-1:0]    hour_s3_ff;
   logic [WEEKDAY_W-1:0] weekday_s3_ff;
   logic [YEAR_W-1:0]    year_s3_in, year_s3_ff;
   logic [DOY_W-1:0]     doy_s3_in, doy_s3_ff;
   logic                 leap_s3_in, leap_s3_ff;

   always_comb begin
      if (doff_s2_ff >= YEAR3_START) begin
         yoff   = 2'd3;
         ystart = YEAR3_START;
      end else if (doff_s2_ff >= YEAR2_START) begin
         yoff   = 2'd2;
         ystart = YEAR2_START;
      end else if (doff_s2_ff >= YEAR1_START) begin
         yoff   = 2'd1;
         ystart = YEAR1_START;
      end else begin
         yoff   = 2'd0;
         ystart = '0;
      end
   end

   assign hour_secs  = 17'(hour_s2_ff) * 17'(SECS_PER_HOUR);
   assign rh_s3_in   = sod_s2_ff - hour_secs[11:0];
   assign doy_full   = doff_s2_ff - ystart;
   assign doy_s3_in  = doy_full[DOY_W-1:0];
   assign year_s3_in = BASE_YEAR + YEAR_W'({blk_s2_ff, 2'b00}) + YEAR_W'(yoff);
   assign leap_s3_in = (yoff == LEAP_SLOT);

   // Stage 4: minute, month and day of month.
   logic [20:0] min_prod;
   logic [5:0]  rh_s4_ff;
   logic [MINUTE_W-1:0]  minute_s4_in, minute_s4_ff;
   logic [HOUR_W-1:0]    hour_s4_ff;
   logic [WEEKDAY_W-1:0] weekday_s4_ff;
   logic [YEAR_W-1:0]    year_s4_ff;
   logic [MONTH_W-1:0]   month_s4_in, month_s4_ff;
   logic [DAY_W-1:0]     day_s4_in, day_s4_ff;

   assign min_prod     = 21'(rh_s3_ff[11:2]) * 21'(MIN_RECIP);
   assign minute_s4_in = min_prod[MIN_SHIFT +: MINUTE_W];

   ucd_month_find u_month_find (
      .doy   (doy_s3_ff),
      .leap  (leap_s3_ff),
      .month (month_s4_in),
      .day   (day_s4_in)
   );

   // Stage 5: second; output register.
   logic [11:0] min_secs;
   logic [SECOND_W-1:0]  second_s5_in, second_s5_ff;
   logic [MINUTE_W-1:0]  minute_s5_ff;
   logic [HOUR_W-1:0]    hour_s5_ff;
   logic [WEEKDAY_W-1:0] weekday_s5_ff;
   logic [YEAR_W-1:0]    year_s5_ff;
   logic [MONTH_W-1:0]   month_s5_ff;
   logic [DAY_W-1:0]     day_s5_ff;

   assign min_secs     = 12'(minute_s4_ff) * 12'(SECS_PER_MIN);
   assign second_s5_in = rh_s4_ff - min_secs[5:0];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         days_s0_ff <= days_s0_in;
         tlo_s0_ff  <= tlo_s0_in;
      end
      if (adv[1]) begin
         sod_s1_ff  <= sod_s1_in;
         blk_s1_ff  <= blk_s1_in;
         days_s1_ff <= days_s1_in;
         wx_s1_ff   <= wx_s1_in;
         wq_s1_ff   <= wq_s1_in;
      end
      if (adv[2]) begin
         sod_s2_ff     <= sod_s2_in;
         hour_s2_ff    <= hour_s2_in;
         weekday_s2_ff <= weekday_s2_in;
         doff_s2_ff    <= doff_s2_in;
         blk_s2_ff     <= blk_s2_in;
      end
      if (adv[3]) begin
         rh_s3_ff      <= rh_s3_in;
         hour_s3_ff    <= hour_s2_ff;
         weekday_s3_ff <= weekday_s2_ff;
         year_s3_ff    <= year_s3_in;
         doy_s3_ff     <= doy_s3_in;
         leap_s3_ff    <= leap_s3_in;
      end
      if (adv[4]) begin
         rh_s4_ff      <= rh_s3_ff[5:0];
         minute_s4_ff  <= minute_s4_in;
         hour_s4_ff    <= hour_s3_ff;
         weekday_s4_ff <= weekday_s3_ff;
         year_s4_ff    <= year_s3_ff;
         month_s4_ff   <= month_s4_in;
         day_s4_ff     <= day_s4_in;
      end
      if (adv[5]) begin
         second_s5_ff  <= second_s5_in;
         minute_s5_ff  <= minute_s4_ff;
         hour_s5_ff    <= hour_s4_ff;
         weekday_s5_ff <= weekday_s4_ff;
         year_s5_ff    <= year_s4_ff;
         month_s5_ff   <= month_s4_ff;
         day_s5_ff     <= day_s4_ff;
      end
   end

   assign rsp_tdata = {7'b0, weekday_s5_ff, second_s5_ff, minute_s5_ff, hour_s5_ff,
                       day_s5_ff, month_s5_ff, year_s5_ff};

   `UCD_ASSERT_IMPLY(a_ready_when_room, clock, reset, !(&valid_ff), req_tready, "pipe has room but refuses a request")
   `UCD_ASSERT_IMPLY(a_doy_range, clock, reset, valid_ff[3], (doy_s3_ff < LAST_LEAP_DOY) || (doy_s3_ff == LAST_LEAP_DOY && leap_s3_ff), "day of year out of range")
   `UCD_ASSERT_IMPLY(a_time_range, clock, reset, rsp_tvalid, (hour_s5_ff <= 5'd23) && (minute_s5_ff <= 6'd59) && (second_s5_ff <= 6'd59), "time of day out of range")
   `UCD_ASSERT_IMPLY(a_date_range, clock, reset, rsp_tvalid, (month_s5_ff >= 4'd1) && (month_s5_ff <= 4'd12) && (day_s5_ff != 5'd0) && (weekday_s5_ff != 3'd0), "date field out of range")

endmodule

FILE: sim/ucd_date_checker.sv
// Checker for the epoch seconds to calendar date converter: predicts each date
// from the accepted requests and compares every accepted response field by field.
// Depends on ucd_pkg for the channel and field widths.
module ucd_date_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ucd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ucd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                    mismatch_count,
   output int unsigned                    dates_pending
);
   import ucd_pkg::*;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
      logic [WEEKDAY_W-1:0] weekday;
   } cal_date_type;

   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                  31, 31, 30, 31, 30, 31};
   localparam int unsigned FEBRUARY = 1;

   cal_date_type expected_dates [$];
   cal_date_type want;
   cal_date_type got;
   int unsigned  errors;

   // Every year divisible by four is taken as a leap year, 2100 included.
   function automatic cal_date_type calendar_from_epoch(input logic [31:0] t);
      cal_date_type d;
      int unsigned  mins;
      int unsigned  hours;
      int unsigned  days;
      int unsigned  rem;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  mlen;
      bit           leap;
      bit           found;
      mins  = t / 60;
      hours = mins / 60;
      days  = hours / 24;
      yr    = 1970 + 4 * (days / 1461);
      rem   = days % 1461;
      if (rem >= 365) begin
         yr++;
         rem -= 365;
      end
      if (rem >= 365) begin
         yr++;
         rem -= 365;
      end
      if (rem >= 366) begin
         yr++;
         rem -= 366;
      end
      leap  = (yr % 4) == 0;
      mon   = 1;
      found = 1'b0;
      for (int i = 0; i < 12; i++) begin
         mlen = DAYS_IN_MONTH[i] + ((leap && i == FEBRUARY) ? 1 : 0);
         if (!found && rem >= mlen) begin
            rem -= mlen;
            mon++;
         end else begin
            found = 1'b1;
         end
      end
      d.year    = YEAR_W'(yr);
      d.month   = MONTH_W'(mon);
      d.day     = DAY_W'(rem + 1);
      d.hour    = HOUR_W'(hours % 24);
      d.minute  = MINUTE_W'(mins % 60);
      d.second  = SECOND_W'(t % 60);
      d.weekday = WEEKDAY_W'(((days + 3) % 7) + 1);
      return d;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(calendar_from_epoch(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.year    = rsp_tdata[11:0];
            got.month   = rsp_tdata[15:12];
            got.day     = rsp_tdata[20:16];
            got.hour    = rsp_tdata[25:21];
            got.minute  = rsp_tdata[31:26];
            got.second  = rsp_tdata[37:32];
            got.weekday = rsp_tdata[40:38];
            if (expected_dates.size() == 0) begin
               $error("response with no request outstanding: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_dates.pop_front();
               check_field("year", want.year, got.year);
               check_field("month", want.month, got.month);
               check_field("day", want.day, got.day);
               check_field("hour", want.hour, got.hour);
               check_field("minute", want.minute, got.minute);
               check_field("second", want.second, got.second);
               check_field("weekday", want.weekday, got.weekday);
               check_field("padding", 0, rsp_tdata[47:41]);
            end
         end
      end
      dates_pending  <= expected_dates.size();
      mismatch_count <= errors;
   end

endmodule

FILE: sim/tb_unix_time_to_calendar_date.sv
// Top of the date converter testbench: clock, reset, request stimulus with
// random gaps and response stalls, and the final verdict.
// Depends on ucd_pkg, the converter RTL and ucd_date_checker.
module tb_unix_time_to_calendar_date;
   import ucd_pkg::*;

   localparam int          RANDOM_REQUESTS = 1930;
   localparam int          QUIET_REQUESTS  = 200;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int          DRAIN_CYCLES    = 4 * NUM_STAGES;
   localparam int          LAST_FULL_DAY   = 49709;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned mismatch_count;
   int unsigned dates_pending;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b1;

   unix_time_to_calendar_date dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ucd_date_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .dates_pending  (dates_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(0, 11)) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic [31:0] t);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
   endtask

   // About half of the random requests sit near the edges of a day, a year or a leap block,
   // where the carries into the calendar fields happen.
   function automatic logic [31:0] random_epoch();
      int unsigned day;
      int unsigned tod;
      int unsigned block_edges [8] = '{0, 364, 365, 729, 730, 1095, 1096, 1460};
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: begin
            day = $urandom_range(0, LAST_FULL_DAY);
            tod = $urandom_range(0, 1) ? 86399 - $urandom_range(0, 3) : $urandom_range(0, 3);
            return 32'(day * 86400 + tod);
         end
         2: begin
            day = 1461 * $urandom_range(0, 33) + block_edges[$urandom_range(0, 7)];
            if (day > LAST_FULL_DAY) begin
               day = LAST_FULL_DAY;
            end
            return 32'(day * 86400 + $urandom_range(0, 86399));
         end
         default: return 32'($urandom_range(0, LAST_FULL_DAY) * 86400
                             + $urandom_range(0, 86399));
      endcase
   endfunction

   initial begin
      logic [31:0] directed [] = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd68169600, 32'd94694399, 32'd946684799, 32'd2147483647, 32'd2147483648,
         32'd4102444800, 32'd4107542400, 32'd4107628800, 32'hFFFF_FFFE, 32'hFFFF_FFFF
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_request(directed[i]);
      end
      // Hold off the sender until the pipeline has fully drained once.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dates_pending != 0) @(posedge clock);
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS - QUIET_REQUESTS) begin
            idling_on = 1'b0;
         end
         send_request(random_epoch());
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dates_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && dates_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
